// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock edge, quiet while reset is held
`define SHA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is held
`define SHA_CHECK_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sha_pkg.sv =====
// shared types, constants and round-constant table for the sha-256 hasher
package sha_pkg;

    typedef struct packed {
        logic [31:0] word;
        logic        last_blk;
    } blk_word_t;

    typedef logic [31:0] word_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t PAD_WORD = 32'h80000000;
    localparam logic [60:0] BYTE_COUNT_MAX = {61{1'b1}};
    localparam logic [3:0] LEN_SLOT = 4'd14;

    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        unique case (t)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/sha256_message_hash_top.sv =====
// sha-256 message hasher: loads each 16-word block, runs 64 rounds, adds into chain
// the core runs one round per cycle and reads no new words until the block is added
// a last word adds padding that may fill one more block, then 8 digest words drain
// the core takes no block while the digest waits to be popped
// rst_n asynchronously returns chain to the initial hash values, counts to zero
module sha256_message_hash_top
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    blk_word_t wq_data, rq_data;
    logic      q_wr, q_rd, q_full, q_empty;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .message_word(message_word), .valid_bytes(valid_bytes), .last_word(last_word),
        .q_full(q_full), .q_wr(q_wr), .q_data(wq_data)
    );

    sha_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(q_wr), .wr_data(wq_data), .q_full(q_full),
        .rd(q_rd), .rd_data(rq_data), .q_empty(q_empty)
    );

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(rq_data), .q_rd(q_rd),
        .empty(empty), .pop(pop), .digest_word(digest_word),
        .digest_index(digest_index), .digest_last(digest_last)
    );

endmodule

// ===== hdl/sha_front.sv =====
// front end: accepts message words, counts bytes and appends padding
module sha_front
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] message_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    input  logic        q_full,
    output logic        q_wr,
    output blk_word_t   q_data
);

    typedef enum logic [2:0] {F_IN, F_PAD, F_ZERO, F_LENH, F_LENL} fstate_t;

    fstate_t     state_reg, state_next;
    logic [60:0] count_reg, count_next;
    logic [3:0]  fill_reg, fill_next;
    logic        accept;
    logic [2:0]  nb;
    logic [31:0] keep, mark;
    logic [60:0] add_n, count_sat;
    logic [63:0] bits;

    assign full   = (state_reg != F_IN) || q_full;
    assign accept = push && !full;
    assign nb     = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
    assign add_n  = last_word ? {58'd0, nb} : 61'd4;
    assign count_sat = (count_reg > (BYTE_COUNT_MAX - add_n)) ? BYTE_COUNT_MAX
                                                              : count_reg + add_n;
    assign bits   = {count_reg, 3'b000};

    always_comb
    begin
        case (nb)
            3'd0:    begin keep = 32'h00000000; mark = 32'h80000000; end
            3'd1:    begin keep = 32'hff000000; mark = 32'h00800000; end
            3'd2:    begin keep = 32'hffff0000; mark = 32'h00008000; end
            default: begin keep = 32'hffffff00; mark = 32'h00000080; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        q_wr = 1'b0;
        q_data.word = 32'd0;
        q_data.last_blk = 1'b0;
        unique case (state_reg)
            F_IN:
            begin
                if (accept)
                begin
                    q_wr = 1'b1;
                    count_next = count_sat;
                    if (!last_word || nb == 3'd4)
                        q_data.word = message_word;
                    else
                        q_data.word = (message_word & keep) | mark;
                    if (last_word)
                        state_next = (nb == 3'd4) ? F_PAD : F_ZERO;
                end
            end
            F_PAD:
            begin
                if (!q_full)
                begin
                    q_wr = 1'b1;
                    q_data.word = PAD_WORD;
                    state_next = F_ZERO;
                end
            end
            F_ZERO:
            begin
                if (fill_reg == LEN_SLOT)
                    state_next = F_LENH;
                else if (!q_full)
                    q_wr = 1'b1;
            end
            F_LENH:
            begin
                if (!q_full)
                begin
                    q_wr = 1'b1;
                    q_data.word = bits[63:32];
                    state_next = F_LENL;
                end
            end
            F_LENL:
            begin
                if (!q_full)
                begin
                    q_wr = 1'b1;
                    q_data.word = bits[31:0];
                    q_data.last_blk = 1'b1;
                    count_next = 61'd0;
                    state_next = F_IN;
                end
            end
            default: state_next = F_IN;
        endcase
        // fill wraps at sixteen words, one block
        fill_next = fill_reg + {3'd0, q_wr};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IN;
            count_reg <= 61'd0;
            fill_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== hdl/sha_fifo.sv =====
// four-entry word queue between the front end and the compression core
module sha_fifo
    import sha_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  blk_word_t wr_data,
    output logic      q_full,
    input  logic      rd,
    output blk_word_t rd_data,
    output logic      q_empty
);

    blk_word_t   mem_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;

    assign q_full  = (cnt_reg == 3'd4);
    assign q_empty = (cnt_reg == 3'd0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !q_full)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr && !q_full)
                wp_reg <= wp_reg + 2'd1;
            if (rd && !q_empty)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr && !q_full} - {2'd0, rd && !q_empty};
        end
    end

endmodule

// ===== hdl/sha_core.sv =====
// back end: loads blocks, runs 64 rounds, adds into chain and presents digest
module sha_core
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  blk_word_t   q_data,
    output logic        q_rd,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    typedef enum logic [1:0] {B_LOAD, B_ROUND, B_ADD, B_OUT} bstate_t;

    bstate_t    state_reg;
    logic [3:0] cnt_reg;
    logic [5:0] t_reg;
    logic [2:0] idx_reg;
    logic       fin_reg;
    word_t      chain_reg [8];
    word_t      win_reg [16];
    word_t      v_reg [8];

    word_t s0, s1, w_new, e_sig, a_sig, ch, maj, t1, t2;

    assign q_rd = (state_reg == B_LOAD) && !q_empty;
    assign empty = (state_reg != B_OUT);
    assign digest_word  = chain_reg[idx_reg];
    assign digest_index = idx_reg;
    assign digest_last  = (idx_reg == 3'd7);

    // window holds W[t..t+15]; the new word is W[t+16]
    always_comb
    begin
        s0 = {win_reg[1][6:0], win_reg[1][31:7]} ^ {win_reg[1][17:0], win_reg[1][31:18]}
           ^ (win_reg[1] >> 3);
        s1 = {win_reg[14][16:0], win_reg[14][31:17]}
           ^ {win_reg[14][18:0], win_reg[14][31:19]} ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
        e_sig = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]};
        a_sig = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]};
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + e_sig + ch + round_k(t_reg) + win_reg[0];
        t2  = a_sig + maj;
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= q_data.word;
            if (cnt_reg == 4'd15)
                v_reg <= chain_reg;
        end
        else if (state_reg == B_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_LOAD;
            cnt_reg   <= 4'd0;
            t_reg     <= 6'd0;
            idx_reg   <= 3'd0;
            fin_reg   <= 1'b0;
            chain_reg <= IV;
        end
        else
        begin
            unique case (state_reg)
                B_LOAD:
                begin
                    if (q_rd)
                    begin
                        cnt_reg <= cnt_reg + 4'd1;
                        if (cnt_reg == 4'd15)
                        begin
                            fin_reg   <= q_data.last_blk;
                            t_reg     <= 6'd0;
                            state_reg <= B_ROUND;
                        end
                    end
                end
                B_ROUND:
                begin
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                        state_reg <= B_ADD;
                end
                B_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + v_reg[i];
                    idx_reg   <= 3'd0;
                    state_reg <= fin_reg ? B_OUT : B_LOAD;
                end
                B_OUT:
                begin
                    if (pop)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            chain_reg <= IV;
                            state_reg <= B_LOAD;
                        end
                    end
                end
                default: state_reg <= B_LOAD;
            endcase
        end
    end

endmodule

// ===== hdl/sha_checker.sv =====
// port-level checker for the sha-256 hasher and its bind
`include "assert_macros.svh"

module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] digest_word,
    input logic [2:0]  digest_index,
    input logic        digest_last
);

    `SHA_CHECK(last_marks_index7,
        !empty |-> (digest_last == (digest_index == 3'd7)),
        "digest_last mismatch")
    `SHA_CHECK(index_steps,
        (!empty && pop && !digest_last)
            |=> (!empty && digest_index == $past(digest_index) + 3'd1),
        "digest index did not step")
    `SHA_CHECK(first_is_zero,
        ($past(empty) && !empty) |-> (digest_index == 3'd0),
        "digest must start at word 0")
    `SHA_CHECK(held_word,
        (!empty && !pop) |=> $stable(digest_word),
        "stalled digest word changed")
    // both sides idle while reset is held
    `SHA_CHECK_ALWAYS(idle_in_reset,
        !rst_n |-> (empty && !full),
        "ports not idle during reset")

endmodule

bind sha256_message_hash_top sha_checker u_sha_checker (
    .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
    .digest_word(digest_word), .digest_index(digest_index), .digest_last(digest_last)
);
